### sv/mes_pkg.sv
// Shared types and constants of the midpoint ellipse stepper.
package mes_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int PIX_W = 12;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Position of a pixel inside a run of four.
	localparam logic [1:0] PIX_PP = 2'd0;
	localparam logic [1:0] PIX_MM = 2'd1;
	localparam logic [1:0] PIX_PM = 2'd2;
	localparam logic [1:0] PIX_MP = 2'd3;

	typedef struct packed {
		logic       command;
		logic [9:0] center_x;
		logic [9:0] center_y;
		logic [9:0] semi_axis_x;
		logic [9:0] semi_axis_y;
		logic [3:0] draw_color;
	} mes_in_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_x;
		logic signed [PIX_W-1:0] pixel_y;
		logic [3:0]              pixel_color;
		logic                    run_last;
		logic                    shape_done;
	} mes_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_AA,
		ST_LD_BB,
		ST_LD_AAB,
		ST_LD_FIN,
		ST_EMIT,
		ST_R2_XX,
		ST_R2_YY,
		ST_R2_A,
		ST_R2_B,
		ST_R2_C,
		ST_R2_D
	} mes_state_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_AA,
		MUL_BB,
		MUL_AAB,
		MUL_XX,
		MUL_YY,
		MUL_BSQ_TMP,
		MUL_ASQ_TMP,
		MUL_ASQ_BSQ
	} mes_mul_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_STORE_ASQ,
		ACT_STORE_BSQ,
		ACT_LOAD_FIN,
		ACT_TMP_XX,
		ACT_TMP_YY,
		ACT_DEC_SET,
		ACT_DEC_ADD,
		ACT_DEC_FIN
	} mes_act_t;

	typedef struct packed {
		logic       load;
		logic       step;
		mes_mul_t   mul_op;
		mes_act_t   act;
		logic [1:0] pix_idx;
	} mes_cmd_t;

	typedef struct packed {
		logic active;
		logic b_zero;
		logic done;
		logic to_r2;
	} mes_sts_t;

endpackage

### sv/mes_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
interface mes_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### sv/mes_ctrl.sv
// Sequencer of the ellipse stepper: handshakes, multiply schedule and run emission.
module mes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_command,
	input  logic              out_ready,
	input  mes_pkg::mes_sts_t sts,
	output logic              in_ready,
	output logic              out_valid,
	output mes_pkg::mes_cmd_t cmd
);
	import mes_pkg::*;

	mes_state_t state_q;
	mes_state_t state_nxt;
	logic [1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= PIX_PP;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_EMIT && out_ready) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_command == CMD_LOAD) begin
						if (!sts.b_zero) begin
							state_nxt = ST_LD_AA;
						end
					end else if (sts.active) begin
						state_nxt = ST_EMIT;
					end
				end
			end
			ST_LD_AA:  state_nxt = ST_LD_BB;
			ST_LD_BB:  state_nxt = ST_LD_AAB;
			ST_LD_AAB: state_nxt = ST_LD_FIN;
			ST_LD_FIN: state_nxt = ST_IDLE;
			ST_EMIT: begin
				if (out_ready && idx_q == PIX_MP) begin
					state_nxt = sts.to_r2 ? ST_R2_XX : ST_IDLE;
				end
			end
			ST_R2_XX: state_nxt = ST_R2_YY;
			ST_R2_YY: state_nxt = ST_R2_A;
			ST_R2_A:  state_nxt = ST_R2_B;
			ST_R2_B:  state_nxt = ST_R2_C;
			ST_R2_C:  state_nxt = ST_R2_D;
			ST_R2_D:  state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		cmd.load = (state_q == ST_IDLE) && in_valid && (in_command == CMD_LOAD);
		cmd.step = (state_q == ST_IDLE) && in_valid && (in_command == CMD_STEP) && sts.active;
		cmd.pix_idx = idx_q;
		cmd.mul_op = MUL_NONE;
		cmd.act = ACT_NONE;
		case (state_q)
			ST_LD_AA: begin
				cmd.mul_op = MUL_AA;
			end
			ST_LD_BB: begin
				cmd.mul_op = MUL_BB;
				cmd.act = ACT_STORE_ASQ;
			end
			ST_LD_AAB: begin
				cmd.mul_op = MUL_AAB;
				cmd.act = ACT_STORE_BSQ;
			end
			ST_LD_FIN: begin
				cmd.act = ACT_LOAD_FIN;
			end
			ST_R2_XX: begin
				cmd.mul_op = MUL_XX;
			end
			ST_R2_YY: begin
				cmd.mul_op = MUL_YY;
				cmd.act = ACT_TMP_XX;
			end
			ST_R2_A: begin
				cmd.mul_op = MUL_BSQ_TMP;
				cmd.act = ACT_TMP_YY;
			end
			ST_R2_B: begin
				cmd.mul_op = MUL_ASQ_TMP;
				cmd.act = ACT_DEC_SET;
			end
			ST_R2_C: begin
				cmd.mul_op = MUL_ASQ_BSQ;
				cmd.act = ACT_DEC_ADD;
			end
			ST_R2_D: begin
				cmd.act = ACT_DEC_FIN;
			end
			default: begin
				cmd.mul_op = MUL_NONE;
				cmd.act = ACT_NONE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes open together");

	a_step_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (out_valid && idx_q == PIX_PP))
		else $error("accepted step did not start a run at its first pixel");

	a_run_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && idx_q == PIX_MP && !sts.to_r2) |=> in_ready)
		else $error("run ended without returning to idle");
`endif

endmodule

### sv/mes_dpath.sv
// Datapath of the ellipse stepper: point state, decision update and shared multiplier.
module mes_dpath #(
	parameter int COORD_BITS = mes_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mes_pkg::mes_in_t  in_data,
	input  mes_pkg::mes_cmd_t cmd,
	output mes_pkg::mes_sts_t sts,
	output mes_pkg::mes_out_t out_data
);
	import mes_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int X_W = CB + 1;
	localparam int SQ_W = 2 * CB;
	localparam int MUL_W = 2 * CB + 2;
	localparam int DEC_W = 2 * MUL_W;
	localparam int SLOPE_W = 3 * CB + 4;

	logic [CB-1:0]      a_in;
	logic [CB-1:0]      b_in;
	logic [CB-1:0]      a_q;
	logic [CB-1:0]      b_q;
	logic [CB-1:0]      cx_q;
	logic [CB-1:0]      cy_q;
	logic [3:0]         color_q;
	logic [SQ_W-1:0]    asq_q;
	logic [SQ_W-1:0]    bsq_q;
	logic [X_W-1:0]     x_q;
	logic [CB-1:0]      y_q;
	logic [SLOPE_W-1:0] sx_q;
	logic [SLOPE_W-1:0] sy_q;
	logic [DEC_W-1:0]   dec_q;
	logic               r2_q;
	logic               active_q;
	logic [DEC_W-1:0]   mul_q;
	logic [MUL_W-1:0]   tmp_q;
	logic [X_W-1:0]     px_q;
	logic [CB-1:0]      py_q;
	logic               done_q;
	logic               sw_q;

	logic [MUL_W-1:0]   op_a;
	logic [MUL_W-1:0]   op_b;
	logic [DEC_W-1:0]   prod;

	logic               dec_neg;
	logic               take_x;
	logic               take_y;
	logic [DEC_W-1:0]   dec_n;
	logic [X_W-1:0]     x_n;
	logic [CB-1:0]      y_n;
	logic [SLOPE_W-1:0] sx_n;
	logic [SLOPE_W-1:0] sy_n;
	logic               done_n;
	logic               sw_n;
	logic [DEC_W-1:0]   init_v;
	logic               init_fix;

	assign a_in = CB'(in_data.semi_axis_x);
	assign b_in = CB'(in_data.semi_axis_y);

	always_comb begin
		case (cmd.mul_op)
			MUL_AA: begin
				op_a = MUL_W'(a_q);
				op_b = MUL_W'(a_q);
			end
			MUL_BB: begin
				op_a = MUL_W'(b_q);
				op_b = MUL_W'(b_q);
			end
			MUL_AAB: begin
				op_a = MUL_W'(asq_q);
				op_b = MUL_W'(b_q);
			end
			MUL_XX: begin
				op_a = MUL_W'(x_q);
				op_b = MUL_W'(x_q);
			end
			MUL_YY: begin
				op_a = MUL_W'(y_q - 1'b1);
				op_b = MUL_W'(y_q - 1'b1);
			end
			MUL_BSQ_TMP: begin
				op_a = MUL_W'(bsq_q);
				op_b = tmp_q;
			end
			MUL_ASQ_TMP: begin
				op_a = MUL_W'(asq_q);
				op_b = tmp_q;
			end
			MUL_ASQ_BSQ: begin
				op_a = MUL_W'(asq_q);
				op_b = MUL_W'(bsq_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;

	// In region one x always advances and y drops when the decision is not
	// negative; in region two y always drops and x advances on a negative one.
	always_comb begin
		dec_neg = dec_q[DEC_W-1];
		take_x = r2_q ? dec_neg : 1'b1;
		take_y = r2_q ? 1'b1 : !dec_neg;
		dec_n = dec_q + (take_x ? DEC_W'(sx_q) : '0) - (take_y ? DEC_W'(sy_q) : '0)
			+ DEC_W'(r2_q ? asq_q : bsq_q);
		x_n = take_x ? x_q + 1'b1 : x_q;
		y_n = take_y ? y_q - 1'b1 : y_q;
		sx_n = take_x ? sx_q + SLOPE_W'({bsq_q, 1'b0}) : sx_q;
		sy_n = take_y ? sy_q - SLOPE_W'({asq_q, 1'b0}) : sy_q;
		done_n = (y_n == '0);
		sw_n = !r2_q && !done_n && !(sx_n < sy_n);
	end

	// Start value b*b - a*a*b + a*a/4, truncated toward zero as a whole.
	always_comb begin
		init_v = DEC_W'(bsq_q) - mul_q + DEC_W'(asq_q >> 2);
		init_fix = init_v[DEC_W-1] && (asq_q[1:0] != 2'b00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			r2_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				active_q <= 1'b0;
			end else if (cmd.act == ACT_LOAD_FIN) begin
				active_q <= 1'b1;
				r2_q <= 1'b0;
			end else if (cmd.act == ACT_DEC_FIN) begin
				r2_q <= 1'b1;
			end else if (cmd.step && done_n) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= prod;
		if (cmd.load && b_in != '0) begin
			a_q <= a_in;
			b_q <= b_in;
			cx_q <= CB'(in_data.center_x);
			cy_q <= CB'(in_data.center_y);
			color_q <= in_data.draw_color;
		end
		if (cmd.step) begin
			px_q <= x_q;
			py_q <= y_q;
			done_q <= done_n;
			sw_q <= sw_n;
			x_q <= x_n;
			y_q <= y_n;
			sx_q <= sx_n;
			sy_q <= sy_n;
			dec_q <= dec_n;
		end
		case (cmd.act)
			ACT_STORE_ASQ: asq_q <= SQ_W'(mul_q);
			ACT_STORE_BSQ: bsq_q <= SQ_W'(mul_q);
			ACT_LOAD_FIN: begin
				x_q <= '0;
				y_q <= b_q;
				sx_q <= '0;
				sy_q <= SLOPE_W'(mul_q) << 1;
				dec_q <= init_v + DEC_W'(init_fix);
			end
			ACT_TMP_XX:  tmp_q <= MUL_W'(mul_q) + MUL_W'(x_q);
			ACT_TMP_YY:  tmp_q <= MUL_W'(mul_q);
			ACT_DEC_SET: dec_q <= mul_q;
			ACT_DEC_ADD: dec_q <= dec_q + mul_q;
			ACT_DEC_FIN: dec_q <= dec_q - mul_q;
			default: begin
			end
		endcase
	end

	assign sts.active = active_q;
	assign sts.b_zero = (b_in == '0);
	assign sts.done = done_q;
	assign sts.to_r2 = sw_q;

	logic              plus_x;
	logic              plus_y;
	logic [PIX_W-1:0]  cx_w;
	logic [PIX_W-1:0]  cy_w;
	logic [PIX_W-1:0]  ox_w;
	logic [PIX_W-1:0]  oy_w;

	always_comb begin
		plus_x = (cmd.pix_idx == PIX_PP) || (cmd.pix_idx == PIX_PM);
		plus_y = (cmd.pix_idx == PIX_PP) || (cmd.pix_idx == PIX_MP);
		cx_w = PIX_W'(cx_q);
		cy_w = PIX_W'(cy_q);
		ox_w = PIX_W'(px_q);
		oy_w = PIX_W'(py_q);
		out_data.pixel_x = plus_x ? cx_w + ox_w : cx_w - ox_w;
		out_data.pixel_y = plus_y ? cy_w + oy_w : cy_w - oy_w;
		out_data.pixel_color = color_q;
		out_data.run_last = (cmd.pix_idx == PIX_MP);
		out_data.shape_done = done_q;
	end

`ifndef SYNTHESIS
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> (sx_q == '0 && !r2_q && y_q == b_q))
		else $error("ellipse did not start at the top of region one");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && done_n) |=> (!active_q && done_q && !sw_q))
		else $error("final step left the ellipse active");
`endif

endmodule

### sv/midpoint_ellipse_stepper.sv
// Midpoint ellipse stepper. A load beat (command 0) latches center, semi-axes and
// color and passes through the states ST_LD_AA, ST_LD_BB, ST_LD_AAB and
// ST_LD_FIN, in which one shared registered multiplier forms a*a, b*b and a*a*b
// for the region-one start value; a load with a zero vertical axis drops the
// current ellipse. A step beat (command 1) is accepted and then sends the four
// mirror pixels (+x,+y), (-x,-y), (+x,-y), (-x,+y) as four output beats, one per
// cycle while the sink is ready. The step that crosses into region two then
// passes through the states ST_R2_XX to ST_R2_D, in which the same multiplier
// builds the region-two start value. A step while no ellipse is active is
// accepted and sends nothing. shape_done marks the four beats of the last run,
// the one whose update brings y to 0.
module midpoint_ellipse_stepper #(
	parameter int COORD_BITS = mes_pkg::COORD_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mes_stream_if.sink   request,
	mes_stream_if.source pixel
);
	import mes_pkg::*;

	mes_cmd_t cmd;
	mes_sts_t sts;
	mes_in_t  in_data;
	mes_out_t out_data;

	assign in_data = request.payload;
	assign pixel.payload = out_data;

	mes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_command(in_data.command),
		.out_ready (pixel.ready),
		.sts       (sts),
		.in_ready  (request.ready),
		.out_valid (pixel.valid),
		.cmd       (cmd)
	);

	mes_dpath #(
		.COORD_BITS(COORD_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.sts     (sts),
		.out_data(out_data)
	);

endmodule

### verif/pixel_run_checker.sv
// Checker that predicts the mirror pixel runs from the request beats and compares them.
`timescale 1ns / 100ps
module pixel_run_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  mes_pkg::mes_in_t  req_beat,
	input  logic              pix_valid,
	input  logic              pix_ready,
	input  mes_pkg::mes_out_t pix_beat,
	output int                fail_count,
	output int                pixels_due
);
	import mes_pkg::*;

	logic [10:0]        off_x;
	logic signed [11:0] off_y;
	logic [19:0]        axis_x_sq;
	logic [19:0]        axis_y_sq;
	logic signed [33:0] slope_x;
	logic signed [33:0] slope_y;
	logic signed [43:0] decision;
	logic               region_two;
	logic               shape_live;
	logic [9:0]         held_cx;
	logic [9:0]         held_cy;
	logic [3:0]         held_color;

	mes_out_t expected_pixels[$];

	function automatic mes_out_t mirror_pixel(input longint px, input longint py,
		input logic last, input logic done);
		mes_out_t p;
		p.pixel_x     = PIX_W'(px);
		p.pixel_y     = PIX_W'(py);
		p.pixel_color = held_color;
		p.run_last    = last;
		p.shape_done  = done;
		return p;
	endfunction

	// Applies one request beat to the shadow state and queues the pixels it causes.
	task automatic trace_request(input mes_in_t beat);
		longint a, b, v, asq, bsq, sx, sy, d, x, y, x0, y0, ym, cx, cy;
		logic   done;
		if (beat.command == CMD_LOAD) begin
			a = longint'(beat.semi_axis_x);
			b = longint'(beat.semi_axis_y);
			shape_live = 1'b0;
			if (b == 0)
				return;
			held_cx    = beat.center_x;
			held_cy    = beat.center_y;
			held_color = beat.draw_color;
			asq        = a * a;
			bsq        = b * b;
			axis_x_sq  = 20'(asq);
			axis_y_sq  = 20'(bsq);
			off_x      = '0;
			off_y      = 12'(b);
			slope_x    = '0;
			slope_y    = 34'(2 * asq * b);
			v = bsq - asq * b + (asq >>> 2);
			// The start value as a whole is truncated toward zero, not toward minus infinity.
			if (v < 0 && (asq % 4) != 0)
				v += 1;
			decision   = 44'(v);
			region_two = 1'b0;
			shape_live = 1'b1;
			return;
		end
		if (!shape_live)
			return;

		asq  = longint'(axis_x_sq);
		bsq  = longint'(axis_y_sq);
		sx   = longint'(slope_x);
		sy   = longint'(slope_y);
		d    = longint'(decision);
		x    = longint'(off_x);
		y    = longint'(off_y);
		cx   = longint'(held_cx);
		cy   = longint'(held_cy);
		x0   = x;
		y0   = y;
		done = 1'b0;

		if (!region_two) begin
			if (d < 0) begin
				d += sx + bsq;
			end else begin
				y  -= 1;
				d  += sx - sy + bsq;
				sy -= 2 * asq;
			end
			x  += 1;
			sx += 2 * bsq;
			if (y <= 0) begin
				done = 1'b1;
			end else if (!(sx < sy)) begin
				ym         = y - 1;
				region_two = 1'b1;
				d          = bsq * (x * x + x) + asq * ym * ym - asq * bsq;
			end
		end else begin
			if (d >= 0) begin
				d += asq - sy;
			end else begin
				x  += 1;
				d  += sx - sy + asq;
				sx += 2 * bsq;
			end
			y  -= 1;
			sy -= 2 * asq;
			if (y <= 0)
				done = 1'b1;
		end

		off_x    = 11'(x);
		off_y    = 12'(y);
		slope_x  = 34'(sx);
		slope_y  = 34'(sy);
		decision = 44'(d);
		if (done)
			shape_live = 1'b0;

		expected_pixels.push_back(mirror_pixel(cx + x0, cy + y0, 1'b0, done));
		expected_pixels.push_back(mirror_pixel(cx - x0, cy - y0, 1'b0, done));
		expected_pixels.push_back(mirror_pixel(cx + x0, cy - y0, 1'b0, done));
		expected_pixels.push_back(mirror_pixel(cx - x0, cy + y0, 1'b1, done));
	endtask

	always @(posedge clk or negedge arst_n) begin
		mes_out_t due;
		int       misses;
		misses = 0;
		if (!arst_n) begin
			off_x      = '0;
			off_y      = '0;
			axis_x_sq  = '0;
			axis_y_sq  = '0;
			slope_x    = '0;
			slope_y    = '0;
			decision   = '0;
			region_two = 1'b0;
			shape_live = 1'b0;
			held_cx    = '0;
			held_cy    = '0;
			held_color = '0;
			expected_pixels.delete();
			fail_count <= 0;
			pixels_due <= 0;
		end else begin
			if (pix_valid && pix_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel beat (%0d, %0d) arrived with no pixel expected",
						pix_beat.pixel_x, pix_beat.pixel_y);
					misses++;
				end else begin
					due = expected_pixels.pop_front();
					if (pix_beat.pixel_x !== due.pixel_x) begin
						$error("pixel_x: expected %0d, got %0d", due.pixel_x, pix_beat.pixel_x);
						misses++;
					end
					if (pix_beat.pixel_y !== due.pixel_y) begin
						$error("pixel_y: expected %0d, got %0d", due.pixel_y, pix_beat.pixel_y);
						misses++;
					end
					if (pix_beat.pixel_color !== due.pixel_color) begin
						$error("pixel_color: expected %0d, got %0d", due.pixel_color,
							pix_beat.pixel_color);
						misses++;
					end
					if (pix_beat.run_last !== due.run_last) begin
						$error("run_last: expected %0d, got %0d", due.run_last,
							pix_beat.run_last);
						misses++;
					end
					if (pix_beat.shape_done !== due.shape_done) begin
						$error("shape_done: expected %0d, got %0d", due.shape_done,
							pix_beat.shape_done);
						misses++;
					end
				end
			end
			if (req_valid && req_ready)
				trace_request(req_beat);
			fail_count <= fail_count + misses;
			pixels_due <= expected_pixels.size();
		end
	end

endmodule

### verif/testbench.sv
// Testbench top: clock, reset, request stimulus, pixel back-pressure and the verdict.
`timescale 1ns / 100ps
module testbench;
	import mes_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 245;
	localparam int DRAIN_CYCLES   = 20;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   quiet_cycles = 0;
	int   fail_count;
	int   pixels_due;

	mes_stream_if #(.payload_t(mes_in_t))  request_ch ();
	mes_stream_if #(.payload_t(mes_out_t)) pixel_ch ();

	midpoint_ellipse_stepper DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.pixel   (pixel_ch)
	);

	pixel_run_checker pixel_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (request_ch.valid),
		.req_ready  (request_ch.ready),
		.req_beat   (request_ch.payload),
		.pix_valid  (pixel_ch.valid),
		.pix_ready  (pixel_ch.ready),
		.pix_beat   (pixel_ch.payload),
		.fail_count (fail_count),
		.pixels_due (pixels_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		pixel_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// The watchdog restarts on every accepted beat of either channel.
	always @(posedge clk) begin
		if (!arst_n || (request_ch.valid && request_ch.ready) ||
			(pixel_ch.valid && pixel_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no beat accepted for %0d cycles", quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic mes_in_t random_request(input logic cmd);
		mes_in_t r;
		r.command     = cmd;
		r.center_x    = 10'($urandom);
		r.center_y    = 10'($urandom);
		r.semi_axis_x = 10'($urandom);
		r.semi_axis_y = 10'($urandom);
		r.draw_color  = 4'($urandom);
		return r;
	endfunction

	task automatic send_request(input mes_in_t beat);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			request_ch.valid <= 1'b0;
			@(posedge clk);
		end
		request_ch.valid   <= 1'b1;
		request_ch.payload <= beat;
		@(posedge clk);
		while (!request_ch.ready)
			@(posedge clk);
	endtask

	task automatic load_shape(input int cx, input int cy, input int ax, input int ay,
		input int color);
		mes_in_t r;
		r             = random_request(CMD_LOAD);
		r.center_x    = 10'(cx);
		r.center_y    = 10'(cy);
		r.semi_axis_x = 10'(ax);
		r.semi_axis_y = 10'(ay);
		r.draw_color  = 4'(color);
		send_request(r);
	endtask

	task automatic step_shape(input int count);
		repeat (count)
			send_request(random_request(CMD_STEP));
	endtask

	initial begin
		int items, roll, ax, ay, steps;
		items              = 0;
		arst_n             = 1'b0;
		request_ch.valid   = 1'b0;
		request_ch.payload = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Steps with nothing loaded, and a load with no vertical axis, give no pixels.
		step_shape(1);
		load_shape(300, 200, 5, 0, 7);
		step_shape(1);
		// Unit circle at the origin: the mirrored coordinates go negative.
		load_shape(0, 0, 1, 1, 15);
		step_shape(3);
		// No horizontal axis traces a vertical segment.
		load_shape(1023, 1023, 0, 3, 0);
		step_shape(4);
		load_shape(1023, 1023, 1023, 1023, 10);
		step_shape(2);
		load_shape(0, 0, 1023, 1, 5);
		step_shape(1);
		// A new load drops the ellipse still being traced.
		load_shape(512, 512, 3, 2, 9);
		step_shape(7);

		while (items < RANDOM_ITEMS) begin
			case (items * 4 / RANDOM_ITEMS)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 58;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 58;
				end
				default: begin
					send_idle_pct = 17;
					stall_pct     = 17;
				end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				load_shape($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), 0, $urandom_range(0, 15));
				step_shape(1);
				items += 2;
			end else begin
				if (roll < 20) begin
					ax = $urandom_range(0, 1023);
					ay = $urandom_range(1, 1023);
				end else begin
					ax = $urandom_range(0, 8);
					ay = $urandom_range(1, 8);
				end
				load_shape($urandom_range(0, 1023), $urandom_range(0, 1023), ax, ay,
					$urandom_range(0, 15));
				// Large shapes are only started; small ones mostly run to their end.
				if (ax + ay > 16)
					steps = $urandom_range(1, 12);
				else if ($urandom_range(0, 3) == 0)
					steps = $urandom_range(1, ax + ay);
				else
					steps = ax + ay + 1;
				step_shape(steps);
				items += 1 + steps;
			end
		end

		request_ch.valid <= 1'b0;
		@(posedge clk);
		while (pixels_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pixels_due != 0)
			$error("%0d expected pixels never arrived", pixels_due);
		if (fail_count == 0 && pixels_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
